>>> rtl/esm_pkg.sv
// shared types and codes for the escaped stream spi master
// no dependencies; imported by every module of the block
package esm_pkg;

   // input opcodes
   localparam logic [1:0] OP_HOST     = 2'd0;
   localparam logic [1:0] OP_STATUS   = 2'd1;
   localparam logic [1:0] OP_READBACK = 2'd2;

   // host stream control bytes
   localparam logic [7:0] BYTE_QUAD     = 8'hFF;
   localparam logic [7:0] BYTE_SINGLE   = 8'hFE;
   localparam logic [7:0] BYTE_SELECT   = 8'hFD;
   localparam logic [7:0] BYTE_POLL     = 8'hFC;
   localparam logic [2:0] CLASS_CONTROL = 3'b111;
   localparam logic [2:0] CLASS_PREFIX  = 3'b110;

   // read-back bytes that need an escape even though printable, and the lowest printable byte
   localparam logic [7:0] BYTE_QUOTE     = 8'h22;
   localparam logic [7:0] BYTE_BACKSLASH = 8'h5C;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;

   // result kinds
   localparam logic [2:0] KIND_BEAT   = 3'd0;
   localparam logic [2:0] KIND_SELECT = 3'd1;
   localparam logic [2:0] KIND_POLL   = 3'd2;
   localparam logic [2:0] KIND_DIROUT = 3'd3;
   localparam logic [2:0] KIND_REPORT = 3'd4;
   localparam logic [2:0] KIND_REJECT = 3'd5;

   localparam int ERROR_COUNT_BITS_DEFAULT = 16;
   localparam int ERROR_TOTAL_BITS         = 16;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   // work for the back end, one entry per item that has results
   typedef enum logic [2:0] {
      CMD_BYTE    = 3'd0,
      CMD_SELECT  = 3'd1,
      CMD_POLL    = 3'd2,
      CMD_DIROUT  = 3'd3,
      CMD_REPORT1 = 3'd4,
      CMD_REPORT2 = 3'd5,
      CMD_REJECT  = 3'd6
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type                    op;
      logic [7:0]                    data_byte;
      logic                          quad;
      logic [ERROR_TOTAL_BITS-1:0]   error_total;
   } cmd_type;

endpackage

>>> rtl/esm_front.sv
// front end: accepts input words, keeps escape / width / poll / error state,
// and classifies each word into a back-end command; depends on esm_pkg
module esm_front #(
   parameter int ERROR_COUNT_BITS = esm_pkg::ERROR_COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             queue_full,
   output logic             push_valid,
   output esm_pkg::cmd_type push_cmd
);
   import esm_pkg::*;

   logic [1:0]                  esc_ff, esc_in;
   logic                        quad_ff, quad_in;
   logic                        await_ff, await_in;
   logic [ERROR_COUNT_BITS-1:0] err_ff, err_in;
   logic [31:0]                 err_wide;
   logic                        accept;
   logic                        has_result;
   logic                        printable;
   logic [7:0]                  data;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign data       = req_tdata;
   assign printable  = (data >= BYTE_SPACE) && !data[7] && (data != BYTE_QUOTE)
                       && (data != BYTE_BACKSLASH);

   always_comb begin
      esc_in             = esc_ff;
      quad_in            = quad_ff;
      await_in           = await_ff;
      err_in             = err_ff;
      has_result         = 1'b1;
      push_cmd.op        = CMD_REJECT;
      push_cmd.data_byte = data;
      push_cmd.quad      = quad_ff;
      case (req_tuser)
         OP_HOST: begin
            if (await_ff) begin
               push_cmd.op = CMD_REJECT;
            end else if (!data[7]) begin
               push_cmd.op = CMD_BYTE;
            end else begin
               case (data[7:5])
                  CLASS_CONTROL: begin
                     has_result = 1'b0;
                     case (data)
                        BYTE_QUAD: begin
                           quad_in = 1'b1;
                        end
                        BYTE_SINGLE: begin
                           quad_in = 1'b0;
                           err_in  = '0;
                        end
                        BYTE_SELECT: begin
                           quad_in     = 1'b0;
                           has_result  = 1'b1;
                           push_cmd.op = CMD_SELECT;
                        end
                        BYTE_POLL: begin
                           quad_in     = 1'b0;
                           await_in    = 1'b1;
                           has_result  = 1'b1;
                           push_cmd.op = CMD_POLL;
                        end
                        default: begin
                           has_result = 1'b0;
                        end
                     endcase
                  end
                  CLASS_PREFIX: begin
                     esc_in     = data[1:0];
                     has_result = 1'b0;
                  end
                  default: begin
                     push_cmd.op        = CMD_BYTE;
                     push_cmd.data_byte = {esc_ff, data[5:0]};
                  end
               endcase
            end
         end
         OP_STATUS: begin
            if (!await_ff) begin
               push_cmd.op = CMD_REJECT;
            end else if (data[0]) begin
               push_cmd.op = CMD_POLL;
            end else begin
               await_in    = 1'b0;
               push_cmd.op = CMD_DIROUT;
               if (data[6] && (err_ff != {ERROR_COUNT_BITS{1'b1}})) begin
                  err_in = ERROR_COUNT_BITS'(err_ff + 1'b1);
               end
            end
         end
         OP_READBACK: begin
            push_cmd.op = printable ? CMD_REPORT1 : CMD_REPORT2;
         end
         default: begin
            push_cmd.op = CMD_REJECT;
         end
      endcase
      // results report the count as it stands after this word
      err_wide             = 32'(err_in);
      push_cmd.error_total = err_wide[ERROR_TOTAL_BITS-1:0];
   end

   assign push_valid = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= '0;
         quad_ff  <= 1'b0;
         await_ff <= 1'b0;
         err_ff   <= '0;
      end else if (accept) begin
         esc_ff   <= esc_in;
         quad_ff  <= quad_in;
         await_ff <= await_in;
         err_ff   <= err_in;
      end
   end

endmodule

>>> rtl/esm_queue.sv
// short command queue between front and back end
// depends on esm_pkg for the command type and depth
module esm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  esm_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output esm_pkg::cmd_type head_cmd
);
   import esm_pkg::*;

   cmd_type                   entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = entries_ff[rd_ptr_ff];
   assign do_push  = push_valid && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                     : QUEUE_PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = (QUEUE_PTR_BITS + 1)'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = (QUEUE_PTR_BITS + 1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/esm_back.sv
// back end: expands each queued command into result words, one per cycle while
// rsp_tready allows, into a registered output stage; depends on esm_pkg
module esm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  esm_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [31:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast
);
   import esm_pkg::*;

   logic [2:0]                  idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic [2:0]                  kind_ff, kind_in;
   logic [3:0]                  bits_ff, bits_in;
   logic                        quad_ff, quad_in;
   logic                        sel_ff, sel_in;
   logic [7:0]                  rep_ff, rep_in;
   logic [ERROR_TOTAL_BITS-1:0] err_ff;
   logic                        last_ff, last_in;
   logic [2:0]                  last_idx;
   logic [2:0]                  bit_pos;
   logic                        load;

   always_comb begin
      case (head_cmd.op)
         CMD_BYTE:    last_idx = head_cmd.quad ? 3'd1 : 3'd7;
         CMD_SELECT:  last_idx = 3'd1;
         CMD_REPORT2: last_idx = 3'd1;
         default:     last_idx = 3'd0;
      endcase
   end

   assign load    = !queue_empty && (!valid_ff || rsp_tready);
   assign last_in = (idx_ff == last_idx);
   assign pop     = load && last_in;
   assign bit_pos = 3'd7 - idx_ff;

   // result fields for beat idx_ff of the head command
   always_comb begin
      kind_in = KIND_REJECT;
      bits_in = '0;
      quad_in = 1'b0;
      sel_in  = 1'b0;
      rep_in  = '0;
      case (head_cmd.op)
         CMD_BYTE: begin
            kind_in = KIND_BEAT;
            quad_in = head_cmd.quad;
            if (head_cmd.quad) begin
               bits_in = idx_ff[0] ? head_cmd.data_byte[3:0] : head_cmd.data_byte[7:4];
            end else begin
               bits_in = {3'b000, head_cmd.data_byte[bit_pos]};
            end
         end
         CMD_SELECT: begin
            kind_in = KIND_SELECT;
            sel_in  = (idx_ff == 3'd0);
         end
         CMD_POLL: begin
            kind_in = KIND_POLL;
         end
         CMD_DIROUT: begin
            kind_in = KIND_DIROUT;
         end
         CMD_REPORT1: begin
            kind_in = KIND_REPORT;
            rep_in  = head_cmd.data_byte;
         end
         CMD_REPORT2: begin
            kind_in = KIND_REPORT;
            rep_in  = idx_ff[0] ? {2'b10, head_cmd.data_byte[5:0]}
                      : {6'b110000, head_cmd.data_byte[7:6]};
         end
         default: begin
            kind_in = KIND_REJECT;
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_in ? 3'd0 : 3'(idx_ff + 1'b1);
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         bits_ff <= bits_in;
         quad_ff <= quad_in;
         sel_ff  <= sel_in;
         rep_ff  <= rep_in;
         err_ff  <= head_cmd.error_total;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {2'b00, err_ff, rep_ff, sel_ff, quad_ff, bits_ff};

endmodule

>>> rtl/escaped_stream_spi_master.sv
// top level of the escaped stream spi master
// depends on esm_pkg, esm_front, esm_queue and esm_back
//
// spi master fed by an escaped host byte stream, with flash status poll replies
// and read-back data arriving on the same input channel (selected by req_tuser).
// each input word is classified by the front end and, if it causes any results,
// placed in a four-entry command queue; words that cause nothing (prefix bytes,
// width and error-clear controls, unused control bytes) are simply absorbed.
// the back end turns each command into result words at one word per cycle while
// rsp_tready allows, through a registered output stage; a word yields eight
// results for a single-width data byte, two for a quad byte, chip select pulse
// or escaped report byte, and one otherwise. the back end's one-result-per-cycle
// expansion sets the sustained rate; the front keeps taking one word per cycle
// while the queue has room, even while a result waits for rsp_tready. every
// result carries the error count as it stood after its input word (low 16 bits)
// and rsp_tlast marks the final result of each input word.
module escaped_stream_spi_master #(
   parameter int ERROR_COUNT_BITS = esm_pkg::ERROR_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] beat_bits, [4] quad_beat, [5] select_level,
                                    // [13:6] report_byte, [29:14] error_total, [31:30] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last result of the input word
);
   import esm_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type head_cmd;

   // classify words and hold the mode / poll / error state
   esm_front #(
      .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // decouples classification from beat expansion
   esm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_cmd   (head_cmd)
   );

   // expand commands into beats, select pulses, poll events, dirout and reject results and report bytes
   esm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

>>> verif/spi_result_checker.sv
// result checker for the escaped stream spi master: watches both streams,
// predicts the result words of every accepted input word and compares them
// depends on esm_pkg for opcodes, control bytes and result kinds
module spi_result_checker #(
   parameter int ERROR_COUNT_BITS = esm_pkg::ERROR_COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          results_left,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import esm_pkg::*;

   localparam int REPORT_LIMIT = 40;

   typedef struct {
      logic [2:0]  kind;
      logic [3:0]  beat_bits;
      logic        quad_beat;
      logic        select_level;
      logic [7:0]  report_byte;
      logic [15:0] error_total;
      logic        last;
   } spi_result_type;

   spi_result_type pending_results[$];
   spi_result_type word_results[$];

   // shadow of the block state
   logic [1:0]                  prefix_bits;
   logic                        quad_width;
   logic [ERROR_COUNT_BITS-1:0] status_errors;
   logic                        polling;

   initial begin
      fail_count = 0;
      results_left = 0;
      results_checked = 0;
   end

   function automatic void add_result(logic [2:0] kind, logic [3:0] bits, logic quad,
                                      logic sel, logic [7:0] rep);
      spi_result_type r;
      r.kind = kind;
      r.beat_bits = bits;
      r.quad_beat = quad;
      r.select_level = sel;
      r.report_byte = rep;
      r.error_total = '0;
      r.last = 1'b0;
      word_results.push_back(r);
   endfunction

   function automatic void shift_out_byte(logic [7:0] b);
      if (quad_width) begin
         add_result(KIND_BEAT, b[7:4], 1'b1, 1'b0, 8'h00);
         add_result(KIND_BEAT, b[3:0], 1'b1, 1'b0, 8'h00);
      end else begin
         for (int i = 7; i >= 0; i--)
            add_result(KIND_BEAT, {3'b000, b[i]}, 1'b0, 1'b0, 8'h00);
      end
   endfunction

   function automatic void host_word(logic [7:0] b);
      if (polling) begin
         add_result(KIND_REJECT, 4'h0, 1'b0, 1'b0, 8'h00);
      end else if (!b[7]) begin
         shift_out_byte(b);
      end else if (b[7:5] == CLASS_CONTROL) begin
         case (b)
            BYTE_QUAD: quad_width = 1'b1;
            BYTE_SINGLE: begin
               status_errors = '0;
               quad_width = 1'b0;
            end
            BYTE_SELECT: begin
               quad_width = 1'b0;
               add_result(KIND_SELECT, 4'h0, 1'b0, 1'b1, 8'h00);
               add_result(KIND_SELECT, 4'h0, 1'b0, 1'b0, 8'h00);
            end
            BYTE_POLL: begin
               quad_width = 1'b0;
               polling = 1'b1;
               add_result(KIND_POLL, 4'h0, 1'b0, 1'b0, 8'h00);
            end
            default: ;
         endcase
      end else if (b[7:5] == CLASS_PREFIX) begin
         prefix_bits = b[1:0];
      end else begin
         shift_out_byte({prefix_bits, b[5:0]});
      end
   endfunction

   function automatic void status_word(logic [7:0] s);
      if (!polling) begin
         add_result(KIND_REJECT, 4'h0, 1'b0, 1'b0, 8'h00);
      end else if (s[0]) begin
         add_result(KIND_POLL, 4'h0, 1'b0, 1'b0, 8'h00);
      end else begin
         polling = 1'b0;
         if (s[6] && status_errors != '1)
            status_errors = status_errors + 1'b1;
         add_result(KIND_DIROUT, 4'h0, 1'b0, 1'b0, 8'h00);
      end
   endfunction

   function automatic void readback_word(logic [7:0] c);
      if (!c[7] && c >= BYTE_SPACE && c != BYTE_QUOTE && c != BYTE_BACKSLASH) begin
         add_result(KIND_REPORT, 4'h0, 1'b0, 1'b0, c);
      end else begin
         add_result(KIND_REPORT, 4'h0, 1'b0, 1'b0, {6'b110000, c[7:6]});
         add_result(KIND_REPORT, 4'h0, 1'b0, 1'b0, {2'b10, c[5:0]});
      end
   endfunction

   function automatic void predict_spi_results(logic [1:0] op, logic [7:0] b);
      spi_result_type r;
      logic [31:0] wide_errors;
      word_results.delete();
      case (op)
         OP_HOST:     host_word(b);
         OP_STATUS:   status_word(b);
         OP_READBACK: readback_word(b);
         default:     add_result(KIND_REJECT, 4'h0, 1'b0, 1'b0, 8'h00);
      endcase
      // every result carries the count as it stands after the word
      wide_errors = 32'(status_errors);
      foreach (word_results[i]) begin
         r = word_results[i];
         r.error_total = wide_errors[15:0];
         r.last = (i == word_results.size() - 1);
         pending_results.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         if (fail_count < REPORT_LIMIT)
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      spi_result_type want;
      if (reset) begin
         prefix_bits = 2'b00;
         quad_width = 1'b0;
         status_errors = '0;
         polling = 1'b0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $error("result word with nothing expected: kind %0d data 0x%0h",
                         rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("beat_bits", 32'(want.beat_bits), 32'(rsp_tdata[3:0]));
               check_field("quad_beat", 32'(want.quad_beat), 32'(rsp_tdata[4]));
               check_field("select_level", 32'(want.select_level), 32'(rsp_tdata[5]));
               check_field("report_byte", 32'(want.report_byte), 32'(rsp_tdata[13:6]));
               check_field("error_total", 32'(want.error_total), 32'(rsp_tdata[29:14]));
               check_field("padding", 32'(0), 32'(rsp_tdata[31:30]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               results_checked++;
            end
         end
         if (req_tvalid && req_tready)
            predict_spi_results(req_tuser, req_tdata);
      end
      results_left = pending_results.size();
   end

endmodule

>>> verif/testbench.sv
// top of the escaped stream spi master testbench: clock, reset, stimulus,
// receiver backpressure and the verdict
// depends on esm_pkg, escaped_stream_spi_master and spi_result_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import esm_pkg::*;

   // the one opcode the block has no use for
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 40;
   localparam int STREAM_ITEMS     = 200;

   typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [1:0]  req_tuser = 2'b00;   // [1:0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [3:0] beat_bits, [4] quad_beat, [5] select_level,
                                    // [13:6] report_byte, [29:14] error_total, [31:30] zero
   logic [2:0]  rsp_tuser;          // [2:0] kind
   logic        rsp_tlast;

   int fail_count;
   int results_left;
   int results_checked;

   // sender bookkeeping
   int burst_left = 0;
   int words_offered = 0;
   int stream_items = 0;

   // set by the stimulus, picked up and cleared by the receiver
   bit long_hold_req = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   escaped_stream_spi_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   spi_result_checker results_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .results_left    (results_left),
      .results_checked (results_checked)
   );

   // offer one word and hold it until the block takes it
   // bursts of random length, random gaps between them; a zero gap keeps
   // tvalid high so back-to-back words never lower and raise it in one step
   task automatic send_word(input logic [1:0] op, input logic [7:0] b);
      int gap;
      logic ready_seen;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= b;
      // inputs only move at rising edges, so tready seen at the falling edge
      // is what the block presents at the next rising edge
      do begin
         @(negedge clock);
         ready_seen = req_tready;
         @(posedge clock);
      end while (!ready_seen);
      words_offered++;
   endtask

   // stop offering and wait for every predicted word to come out
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (results_left != 0) @(posedge clock);
   endtask

   // receiver: a stall pattern redrawn at random, plus one long hold-off
   // requested by the stimulus and counted out here
   initial begin
      int hold_left;
      int mode_left;
      rx_pattern_type pattern;
      hold_left = 0;
      mode_left = 0;
      pattern = RX_FREE;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            pattern = rx_pattern_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (pattern)
               RX_FREE:     rsp_tready <= 1'b1;
               RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ((mode_left % 8) < 4);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int choice;
      int count;
      bit hold_done;
      bit drain_done;
      hold_done = 1'b0;
      drain_done = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, escapes, width changes, select pulse,
      // a poll with a busy status and an error, and every reject path
      send_word(OP_HOST, 8'h00);
      send_word(OP_HOST, 8'h7F);
      send_word(OP_HOST, 8'hC3);          // prefix, top bits 11
      send_word(OP_HOST, 8'h80);          // goes out as 0xc0
      send_word(OP_HOST, 8'hBF);          // goes out as 0xff
      send_word(OP_HOST, BYTE_QUAD);
      send_word(OP_HOST, 8'h3C);          // two nibble beats
      send_word(OP_HOST, 8'h9A);          // escaped byte in quad width
      send_word(OP_HOST, 8'hE5);          // unused escape, absorbed
      send_word(OP_HOST, 8'hFB);          // unused escape, absorbed
      send_word(OP_HOST, BYTE_SELECT);    // pulse, back to single width
      send_word(OP_HOST, 8'h01);
      send_word(OP_HOST, BYTE_POLL);
      send_word(OP_HOST, 8'h10);          // host byte during a poll
      send_word(OP_STATUS, 8'hFF);        // still busy
      send_word(OP_STATUS, 8'h40);        // done, with an error
      send_word(OP_STATUS, 8'h00);        // status with no poll open
      send_word(OP_READBACK, 8'h20);      // lowest printable
      send_word(OP_READBACK, BYTE_QUOTE);
      send_word(OP_READBACK, BYTE_BACKSLASH);
      send_word(OP_READBACK, 8'h1F);
      send_word(OP_READBACK, 8'hFF);
      send_word(OP_SPARE, 8'hAA);
      send_word(OP_HOST, BYTE_SINGLE);    // clears the error count
      send_word(OP_HOST, 8'hC0);          // prefix back to 00

      // random: mostly well-formed sequences with random content, some noise
      while (stream_items < STREAM_ITEMS) begin
         // fill the block while the receiver holds off
         if (!hold_done && stream_items >= 60) begin
            long_hold_req = 1'b1;
            hold_done = 1'b1;
         end
         // let everything drain once before carrying on
         if (!drain_done && stream_items >= 130) begin
            drain_results();
            drain_done = 1'b1;
         end
         choice = $urandom_range(0, 99);
         if (choice < 20) begin
            send_word(OP_HOST, 8'($urandom_range(0, 127)));
            stream_items++;
         end else if (choice < 32) begin
            // prefix then a few escaped bytes that reuse it
            send_word(OP_HOST, 8'hC0 | 8'($urandom_range(0, 31)));
            count = $urandom_range(1, 3);
            repeat (count) begin
               send_word(OP_HOST, 8'h80 | 8'($urandom_range(0, 63)));
               stream_items++;
            end
         end else if (choice < 40) begin
            send_word(OP_HOST, $urandom_range(0, 1) ? BYTE_QUAD : BYTE_SINGLE);
         end else if (choice < 46) begin
            send_word(OP_HOST, BYTE_SELECT);
            stream_items++;
         end else if (choice < 62) begin
            // poll: busy replies, sometimes a stray word, then a final status
            send_word(OP_HOST, BYTE_POLL);
            stream_items++;
            count = $urandom_range(0, 3);
            repeat (count) begin
               send_word(OP_STATUS, 8'($urandom_range(0, 255)) | 8'h01);
               stream_items++;
            end
            if ($urandom_range(0, 3) == 0) begin
               send_word($urandom_range(0, 1) ? OP_HOST : OP_READBACK,
                         8'($urandom_range(0, 255)));
               stream_items++;
            end
            send_word(OP_STATUS, 8'($urandom_range(0, 255)) & 8'hFE);
            stream_items++;
         end else if (choice < 82) begin
            count = $urandom_range(1, 3);
            repeat (count) begin
               send_word(OP_READBACK, 8'($urandom_range(0, 255)));
               stream_items++;
            end
         end else begin
            // noise: any opcode with any byte
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            stream_items++;
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (results_left != 0)
         $error("%0d expected result words never arrived", results_left);
      $display("covered %0d words: directed escapes, width changes, select, polls,",
               words_offered);
      $display("read-back escapes and rejects; %0d result words checked under backpressure",
               results_checked);
      if (fail_count == 0 && results_left == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
